/* rtl/wpp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wpp_pkg;

    // Chunk tags as they appear little-endian in a 32-bit word.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [31:0] FMT_TAIL_BYTES = 32'd8;
    localparam logic [31:0] RATE_RESET     = 32'd44100;

    typedef enum logic [2:0] {
        ST_SAMPLE    = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_NOT_PCM   = 3'd3,
        ST_NOT_MONO  = 3'd4,
        ST_BAD_RATE  = 3'd5
    } t_status;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] sample;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_beat;

endpackage
`default_nettype wire

/* rtl/wpp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface wpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface
`default_nettype wire

/* rtl/wpp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface wpp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, output status, output sample, output last, input ready);
    modport sink   (input valid, input status, input sample, input last, output ready);
endinterface
`default_nettype wire

/* rtl/wav_pcm_stream_parser.sv */
`timescale 1ns / 1ps
// Output: a sample or error is registered into the output register, or into the skid entry while the sink stalls.
// Throughput: one input byte per cycle; the two-entry output buffer lets a byte be taken
// while a finished result still waits, so input stalls only when both entries are full.
// Reset: synchronous, active low; clears the parse state and output buffer and loads
// expected_rate with 44100.
`default_nettype none
module wav_pcm_stream_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wpp_in_if.sink           i_in,
    wpp_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    import wpp_pkg::*;

    // The user must write the expected sample rate only while the block is idle (the block
    // itself does not enforce it), so the parser may compare against it directly.
    logic [31:0] r_expected_rate;

    logic         take;
    logic         can_take;
    t_result_beat parse_res;
    t_result      out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_expected_rate <= i_cfg_wdata;
        end
    end

    // A beat is taken whenever the skid entry is empty; the parser state
    // advances on every taken beat, with or without a result.
    assign i_in.ready = can_take;
    assign take       = i_in.valid & can_take;

    wpp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_in.data_byte),
        .i_start_of_file (i_in.start_of_file),
        .i_expected_rate (r_expected_rate),
        .o_result        (parse_res)
    );

    // Output register plus skid entry, so a stalled sink does not hold back
    // the byte stream until two results are pending.
    wpp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (parse_res),
        .o_can_take (can_take),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (out_res)
    );

    assign o_out.status = out_res.status;
    assign o_out.sample = out_res.sample;
    assign o_out.last   = out_res.last;

endmodule
`default_nettype wire

/* rtl/wpp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
module wpp_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_start_of_file,
    input  wire logic [31:0]           i_expected_rate,
    output wpp_pkg::t_result_beat      o_result
);
    import wpp_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF_ID      = 4'd0,
        PH_RIFF_SIZE    = 4'd1,
        PH_WAVE_ID      = 4'd2,
        PH_FSEARCH_ID   = 4'd3,
        PH_FSEARCH_SIZE = 4'd4,
        PH_FSEARCH_SKIP = 4'd5,
        PH_FMT_SIZE     = 4'd6,
        PH_FMT_FORMAT   = 4'd7,
        PH_FMT_CHAN     = 4'd8,
        PH_FMT_RATE     = 4'd9,
        PH_DSEARCH_ID   = 4'd10,
        PH_DSEARCH_SIZE = 4'd11,
        PH_DSEARCH_SKIP = 4'd12,
        PH_DATA_SIZE    = 4'd13,
        PH_DATA         = 4'd14,
        PH_HALT         = 4'd15
    } t_phase;

    t_phase      r_phase, n_phase, e_phase;
    logic [1:0]  r_idx, n_idx, e_idx;
    logic [31:0] r_shift, n_shift, e_shift;
    logic [31:0] r_skip, n_skip, e_skip;
    logic        r_size_ok, n_size_ok, e_size_ok;
    logic [31:0] r_data_rem, n_data_rem, e_data_rem;
    logic [7:0]  r_low, n_low, e_low;
    logic        r_low_held, n_low_held, e_low_held;

    logic [31:0] field;
    logic [31:0] data_rem_dec;
    logic        done4;
    logic        done2;
    logic        gather4;
    logic        gather2;
    t_result_beat res;

    always_comb begin
        // A start-of-file beat is parsed against freshly cleared state.
        if (i_start_of_file) begin
            e_phase    = PH_RIFF_ID;
            e_idx      = 2'd0;
            e_shift    = 32'd0;
            e_skip     = 32'd0;
            e_size_ok  = 1'b0;
            e_data_rem = 32'd0;
            e_low      = 8'd0;
            e_low_held = 1'b0;
        end else begin
            e_phase    = r_phase;
            e_idx      = r_idx;
            e_shift    = r_shift;
            e_skip     = r_skip;
            e_size_ok  = r_size_ok;
            e_data_rem = r_data_rem;
            e_low      = r_low;
            e_low_held = r_low_held;
        end

        field        = e_shift | ({24'd0, i_data_byte} << {e_idx, 3'b000});
        done4        = (e_idx == 2'd3);
        done2        = (e_idx != 2'd0);
        data_rem_dec = e_data_rem - 32'd1;

        n_phase    = e_phase;
        n_idx      = e_idx;
        n_shift    = e_shift;
        n_skip     = e_skip;
        n_size_ok  = e_size_ok;
        n_data_rem = e_data_rem;
        n_low      = e_low;
        n_low_held = e_low_held;

        res.valid      = 1'b0;
        res.res.status = ST_SAMPLE;
        res.res.sample = 16'sd0;
        res.res.last   = 1'b0;

        gather4 = 1'b0;
        gather2 = 1'b0;

        case (e_phase)
            PH_RIFF_ID: begin
                gather4 = 1'b1;
                if (done4) begin
                    if (field != TAG_RIFF) begin
                        n_phase        = PH_HALT;
                        res.valid      = 1'b1;
                        res.res.status = ST_NOT_RIFF;
                    end else begin
                        n_phase = PH_RIFF_SIZE;
                    end
                end
            end
            PH_RIFF_SIZE: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_phase = PH_WAVE_ID;
                end
            end
            PH_WAVE_ID: begin
                gather4 = 1'b1;
                if (done4) begin
                    if (field != TAG_WAVE) begin
                        n_phase        = PH_HALT;
                        res.valid      = 1'b1;
                        res.res.status = ST_NOT_WAVE;
                    end else begin
                        n_phase = PH_FSEARCH_ID;
                    end
                end
            end
            PH_FSEARCH_ID: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_phase = (field == TAG_FMT) ? PH_FMT_SIZE : PH_FSEARCH_SIZE;
                end
            end
            PH_DSEARCH_ID: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_phase = (field == TAG_DATA) ? PH_DATA_SIZE : PH_DSEARCH_SIZE;
                end
            end
            PH_FSEARCH_SIZE: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_skip  = field;
                    n_phase = (field == 32'd0) ? PH_FSEARCH_ID : PH_FSEARCH_SKIP;
                end
            end
            PH_DSEARCH_SIZE: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_skip  = field;
                    n_phase = (field == 32'd0) ? PH_DSEARCH_ID : PH_DSEARCH_SKIP;
                end
            end
            PH_FSEARCH_SKIP, PH_DSEARCH_SKIP: begin
                if (e_skip != 32'd0) begin
                    n_skip = e_skip - 32'd1;
                end
                if (e_skip <= 32'd1) begin
                    n_phase = (e_phase == PH_FSEARCH_SKIP) ? PH_FSEARCH_ID : PH_DSEARCH_ID;
                end
            end
            PH_FMT_SIZE: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_size_ok = (field == FMT_CHUNK_SIZE);
                    n_phase   = PH_FMT_FORMAT;
                end
            end
            PH_FMT_FORMAT: begin
                gather2 = 1'b1;
                if (done2) begin
                    if (field != 32'd1 || !e_size_ok) begin
                        n_phase        = PH_HALT;
                        res.valid      = 1'b1;
                        res.res.status = ST_NOT_PCM;
                    end else begin
                        n_phase = PH_FMT_CHAN;
                    end
                end
            end
            PH_FMT_CHAN: begin
                gather2 = 1'b1;
                if (done2) begin
                    if (field != 32'd1) begin
                        n_phase        = PH_HALT;
                        res.valid      = 1'b1;
                        res.res.status = ST_NOT_MONO;
                    end else begin
                        n_phase = PH_FMT_RATE;
                    end
                end
            end
            PH_FMT_RATE: begin
                gather4 = 1'b1;
                if (done4) begin
                    if (field != i_expected_rate) begin
                        n_phase        = PH_HALT;
                        res.valid      = 1'b1;
                        res.res.status = ST_BAD_RATE;
                    end else begin
                        n_skip  = FMT_TAIL_BYTES;
                        n_phase = PH_DSEARCH_SKIP;
                    end
                end
            end
            PH_DATA_SIZE: begin
                gather4 = 1'b1;
                if (done4) begin
                    n_data_rem = field;
                    n_low_held = 1'b0;
                    n_phase    = (field == 32'd0) ? PH_HALT : PH_DATA;
                end
            end
            PH_DATA: begin
                if (e_data_rem == 32'd0) begin
                    n_phase = PH_HALT;
                end else begin
                    n_data_rem = data_rem_dec;
                    if (!e_low_held) begin
                        n_low      = i_data_byte;
                        n_low_held = 1'b1;
                    end else begin
                        n_low_held     = 1'b0;
                        res.valid      = 1'b1;
                        res.res.sample = {i_data_byte, e_low};
                        res.res.last   = (data_rem_dec < 32'd2);
                    end
                    if (data_rem_dec == 32'd0) begin
                        n_phase = PH_HALT;
                    end
                end
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase

        // Little-endian field collection shared by all header field phases (not the skip phases).
        if ((gather4 && done4) || (gather2 && done2)) begin
            n_shift = 32'd0;
            n_idx   = 2'd0;
        end else if (gather4 || gather2) begin
            n_shift = field;
            n_idx   = e_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF_ID;
            r_idx      <= 2'd0;
            r_shift    <= 32'd0;
            r_skip     <= 32'd0;
            r_size_ok  <= 1'b0;
            r_data_rem <= 32'd0;
            r_low      <= 8'd0;
            r_low_held <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_shift    <= n_shift;
            r_skip     <= n_skip;
            r_size_ok  <= n_size_ok;
            r_data_rem <= n_data_rem;
            r_low      <= n_low;
            r_low_held <= n_low_held;
        end
    end

    always_comb begin
        o_result       = res;
        o_result.valid = res.valid & i_take;
    end

endmodule
`default_nettype wire

/* rtl/wpp_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none
module wpp_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire wpp_pkg::t_result_beat i_result,
    output logic                       o_can_take,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output wpp_pkg::t_result           o_result
);
    import wpp_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    slot_free;

    assign slot_free  = !r_out_valid || i_ready;
    assign o_can_take = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (slot_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (slot_free) begin
                r_out_valid <= i_result.valid;
            end else if (i_result.valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (slot_free) begin
                r_out <= r_skid;
            end
        end else if (slot_free) begin
            if (i_result.valid) begin
                r_out <= i_result.res;
            end
        end else if (i_result.valid) begin
            r_skid <= i_result.res;
        end
    end

endmodule
`default_nettype wire
